// ===== design/sliding_window_maximum_core_macros.svh =====
// Assertion macros for the sliding window maximum core
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum core
`default_nettype none

package swm_pkg;

    // Width of the window length register, fill count and candidate age
    localparam int LEN_W = 7;
    localparam int AGE_W = 7;

    localparam logic [LEN_W-1:0] FILL_CAP   = '1;
    localparam logic [LEN_W-1:0] WLEN_RESET = LEN_W'(1);

    // What each cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_COMMIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/swm_if.sv =====
// Channel interfaces: sample input, result output, window length write
`default_nettype none

interface swm_sample_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_result_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [swm_pkg::LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/swm_cell.sv =====
// One candidate cell: holds a value, its age and a valid bit
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cell_ctrl_t                     ctrl,
    input  wire logic                           clear,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic [LEN_W-1:0]               wlen,
    input  wire logic                           nbr_valid,
    input  wire logic signed [SAMPLE_WIDTH-1:0] nbr_value,
    input  wire logic [AGE_W-1:0]               nbr_age,
    input  wire logic                           src_keep,
    input  wire logic                           prev_keep,
    output logic                                valid,
    output logic signed [SAMPLE_WIDTH-1:0]      value,
    output logic [AGE_W-1:0]                    age,
    output logic                                keep,
    output logic                                expired
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;
    logic [AGE_W-1:0]               age_reg;
    logic [AGE_W-1:0]               age_next;
    logic [AGE_W:0]                 age_inc;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    logic [AGE_W-1:0]               src_age;

    // Expiry after this beat's ageing, survival against the new sample
    assign age_inc = {1'b0, age_reg} + 1'b1;
    assign expired = valid_reg && (age_inc >= {1'b0, wlen});
    assign keep    = valid_reg && !clear && !expired && (value_reg > sample);

    // On commit the survivor comes from here or from the right neighbour
    assign src_value = ctrl.shift ? nbr_value : value_reg;
    assign src_age   = ctrl.shift ? nbr_age : age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_SHIFT:
            begin
                valid_next = nbr_valid;
                value_next = nbr_value;
                age_next   = nbr_age;
            end
            CELL_COMMIT:
            begin
                valid_next = src_keep || prev_keep;
                value_next = src_keep ? src_value : sample;
                age_next   = src_keep ? AGE_W'(src_age + 1'b1) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

// ===== design/sliding_window_maximum_core.sv =====
// Sliding window maximum over a stream of signed samples.
//
// samples: one beat carries a sample and start_req; start_req clears the
// window so that the sample opens a new stream. results: one beat per
// sample once window_length samples have arrived since the last start,
// carrying the maximum of the latest window_length samples. Nothing is
// sent while the window fills or when window_length is 0 or above
// WINDOW_MAX. cfg: writes window_length; taken only while no sample is
// held. A row of WINDOW_MAX cells keeps the candidate list, oldest in
// cell 0; every cell compares against the new sample at once.
// Samples pass the hold register, then the output register. Throughput:
// one sample per cycle unless the output stalls; after window_length has
// been shortened, a sample that expires more than one candidate waits as
// the row shifts left one cell per step. Reset empties the list, sets
// window_length to 1. A stalled result is held in the output register;
// the held sample then waits and the input stalls behind it.
`default_nettype none
`include "sliding_window_maximum_core_macros.svh"

module sliding_window_maximum_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    swm_sample_if.sink  samples,
    swm_result_if.source results,
    swm_cfg_if.sink     cfg
);

    logic                           hold_valid_reg;
    logic                           hold_start_reg;
    logic signed [SAMPLE_WIDTH-1:0] hold_sample_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;
    logic [LEN_W-1:0]               fill_reg;
    logic [LEN_W-1:0]               fill_next;
    logic [LEN_W-1:0]               wlen_reg;

    logic [WINDOW_MAX:0]              c_valid;
    logic [WINDOW_MAX:0]              c_keep;
    logic [WINDOW_MAX:0]              c_exp;
    logic signed [SAMPLE_WIDTH-1:0]   c_value [WINDOW_MAX+1];
    logic [AGE_W-1:0]                 c_age   [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]            kp;
    logic [WINDOW_MAX-1:0]            kprev;

    logic                           can_out;
    logic                           done;
    logic                           shift_step;
    logic                           shift;
    logic                           emit;
    logic signed [SAMPLE_WIDTH-1:0] head_value;
    cell_ctrl_t                     ctrl;

    // Sequencing of the held beat
    assign can_out    = !out_valid_reg || results.ready;
    assign done       = hold_valid_reg && (hold_start_reg || !c_exp[1]) && can_out;
    assign shift_step = hold_valid_reg && !hold_start_reg && c_exp[1];
    assign samples.ready = !hold_valid_reg || done;
    assign cfg.ready     = !hold_valid_reg;

    // Oldest candidate expires, or the row is full: survivors move left
    assign shift = c_exp[0] || c_keep[WINDOW_MAX-1];

    always_comb
    begin
        ctrl.shift = shift;
        if (done)
            ctrl.op = CELL_COMMIT;
        else if (shift_step)
            ctrl.op = CELL_SHIFT;
        else
            ctrl.op = CELL_HOLD;
    end

    // Padding beyond the last cell
    assign c_valid[WINDOW_MAX] = 1'b0;
    assign c_keep[WINDOW_MAX]  = 1'b0;
    assign c_exp[WINDOW_MAX]   = 1'b0;
    assign c_value[WINDOW_MAX] = '0;
    assign c_age[WINDOW_MAX]   = '0;

    // Cell row
    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        assign kp[g] = shift ? c_keep[g+1] : c_keep[g];
        if (g == 0)
        begin : g_first
            assign kprev[g] = 1'b1;
        end
        else
        begin : g_rest
            assign kprev[g] = kp[g-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .clear     (hold_start_reg),
            .sample    (hold_sample_reg),
            .wlen      (wlen_reg),
            .nbr_valid (c_valid[g+1]),
            .nbr_value (c_value[g+1]),
            .nbr_age   (c_age[g+1]),
            .src_keep  (kp[g]),
            .prev_keep (kprev[g]),
            .valid     (c_valid[g]),
            .value     (c_value[g]),
            .age       (c_age[g]),
            .keep      (c_keep[g]),
            .expired   (c_exp[g])
        );
    end

    // New head of the list and the result decision
    assign head_value = kp[0] ? (shift ? c_value[1] : c_value[0]) : hold_sample_reg;
    assign fill_next  = hold_start_reg ? LEN_W'(1) :
                        ((fill_reg == FILL_CAP) ? FILL_CAP : fill_reg + 1'b1);
    assign emit = done && (wlen_reg != '0) && (int'(wlen_reg) <= WINDOW_MAX)
                  && (fill_next >= wlen_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fill_reg       <= '0;
            wlen_reg       <= WLEN_RESET;
        end
        else
        begin
            if (samples.valid && samples.ready)
                hold_valid_reg <= 1'b1;
            else if (done)
                hold_valid_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            if (done)
                fill_reg <= fill_next;

            if (cfg.valid && cfg.ready)
                wlen_reg <= cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            hold_sample_reg <= samples.sample;
            hold_start_reg  <= samples.start_req;
        end
        if (emit)
            out_data_reg <= head_value;
    end

    assign results.valid      = out_valid_reg;
    assign results.window_max = out_data_reg;

    // Checks
    `SWM_ASSERT_NEXT(a_head_after_commit, clk, rst_n, done, c_valid[0])
    `SWM_ASSERT_NOW(a_valid_prefix, clk, rst_n, 1'b1,
        (c_valid[WINDOW_MAX-1:0] & (c_valid[WINDOW_MAX-1:0] + 1'b1)) == '0)
    `SWM_ASSERT_NOW(a_result_from_commit, clk, rst_n, $rose(out_valid_reg), $past(done))
    `SWM_ASSERT_NEXT(a_shift_keeps_beat, clk, rst_n, shift_step,
        hold_valid_reg && $stable(hold_sample_reg))

endmodule

`default_nettype wire
